[design/pcc_pkg.sv]
// ----------------------------------------------------------------------------
// pcc_pkg
// Types and constants shared by the Pearson correlation block.
// ----------------------------------------------------------------------------
package pcc_pkg;

    localparam int DEF_MAX_SAMPLES = 65536;
    localparam int DEF_SAMPLE_BITS = 16;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic signed [15:0] sample_a;
        logic signed [15:0] sample_b;
        logic               last;
    } pcc_in_t;

    typedef struct packed {
        logic signed [15:0] correlation;
        logic               degenerate;
        logic               overflow;
    } pcc_out_t;

    // Totals of one finished set, handed from the front to the back.
    typedef struct packed {
        logic [31:0] count;
        logic [63:0] sum_a;
        logic [63:0] sum_b;
        logic [63:0] sum_aa;
        logic [63:0] sum_bb;
        logic [63:0] sum_ab;
        logic        overflow;
    } pcc_snap_t;

endpackage

[design/pcc_queue.sv]
// ----------------------------------------------------------------------------
// pcc_queue
// Short register queue of finished set totals between front and back.
// ----------------------------------------------------------------------------
module pcc_queue
    import pcc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  pcc_snap_t push_data,
    output logic      full,
    input  logic      pop,
    output logic      avail,
    output pcc_snap_t pop_data
);

    pcc_snap_t              entry_reg [QUEUE_DEPTH];
    logic [QUEUE_PW-1:0]    wr_ptr_reg;
    logic [QUEUE_PW-1:0]    rd_ptr_reg;
    logic [QUEUE_CW-1:0]    count_reg;

    assign full     = (count_reg == QUEUE_CW'(QUEUE_DEPTH));
    assign avail    = (count_reg != '0);
    assign pop_data = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push && !full)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push && !full)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QUEUE_PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop && avail)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QUEUE_PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if ((push && !full) && !(pop && avail))
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (!(push && !full) && (pop && avail))
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

[design/pcc_front.sv]
// ----------------------------------------------------------------------------
// pcc_front
// Takes sample pairs, forms their products and keeps the running sums.
// A pair marked last closes the set and its totals enter the queue.
// ----------------------------------------------------------------------------
module pcc_front
    import pcc_pkg::*;
#(
    parameter int MAX_SAMPLES = DEF_MAX_SAMPLES,
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      sample_valid,
    output logic      sample_stall,
    input  pcc_in_t   sample,
    output logic      push,
    output pcc_snap_t push_data,
    input  logic      full
);

    localparam int          CW        = $clog2(MAX_SAMPLES + 1);
    localparam logic [15:0] MASK      = (SAMPLE_BITS >= 16) ? 16'hFFFF
                                        : 16'((32'd1 << SAMPLE_BITS) - 32'd1);
    localparam bit          HAS_SIGN  = (SAMPLE_BITS <= 16);
    localparam int          SIGN_IDX  = (SAMPLE_BITS > 16) ? 15 : SAMPLE_BITS - 1;
    localparam logic [16:0] SIGN_WGT  = 17'((32'd1 << SAMPLE_BITS) & 32'h1FFFF);

    logic signed [16:0] val_a;
    logic signed [16:0] val_b;
    logic [15:0]        raw_a;
    logic [15:0]        raw_b;

    logic               p_valid_reg;
    logic               p_last_reg;
    logic signed [16:0] p_a_reg;
    logic signed [16:0] p_b_reg;
    logic signed [33:0] p_aa_reg;
    logic signed [33:0] p_bb_reg;
    logic signed [33:0] p_ab_reg;

    logic [CW-1:0]      count_reg;
    logic [63:0]        sum_a_reg;
    logic [63:0]        sum_b_reg;
    logic [63:0]        sum_aa_reg;
    logic [63:0]        sum_bb_reg;
    logic [63:0]        sum_ab_reg;
    logic               ovf_reg;

    logic               blocked;
    logic               accept;
    logic               act;
    logic               room;
    logic [CW-1:0]      count_next;
    logic [63:0]        sum_a_next;
    logic [63:0]        sum_b_next;
    logic [63:0]        sum_aa_next;
    logic [63:0]        sum_bb_next;
    logic [63:0]        sum_ab_next;
    logic               ovf_next;

    // The low SAMPLE_BITS bits are read as two's complement.
    assign raw_a = sample.sample_a & MASK;
    assign raw_b = sample.sample_b & MASK;
    assign val_a = (HAS_SIGN && raw_a[SIGN_IDX]) ? $signed({1'b0, raw_a} - SIGN_WGT)
                                                 : $signed({1'b0, raw_a});
    assign val_b = (HAS_SIGN && raw_b[SIGN_IDX]) ? $signed({1'b0, raw_b} - SIGN_WGT)
                                                 : $signed({1'b0, raw_b});

    assign blocked      = p_valid_reg && p_last_reg && full;
    assign sample_stall = blocked;
    assign accept       = sample_valid && !sample_stall;
    assign act          = p_valid_reg && !blocked;
    assign room         = (count_reg < CW'(MAX_SAMPLES));

    always_comb
    begin
        count_next  = count_reg;
        sum_a_next  = sum_a_reg;
        sum_b_next  = sum_b_reg;
        sum_aa_next = sum_aa_reg;
        sum_bb_next = sum_bb_reg;
        sum_ab_next = sum_ab_reg;
        ovf_next    = ovf_reg;
        if (room)
        begin
            count_next  = count_reg + 1'b1;
            sum_a_next  = sum_a_reg  + {{47{p_a_reg[16]}}, p_a_reg};
            sum_b_next  = sum_b_reg  + {{47{p_b_reg[16]}}, p_b_reg};
            sum_aa_next = sum_aa_reg + {{30{p_aa_reg[33]}}, p_aa_reg};
            sum_bb_next = sum_bb_reg + {{30{p_bb_reg[33]}}, p_bb_reg};
            sum_ab_next = sum_ab_reg + {{30{p_ab_reg[33]}}, p_ab_reg};
        end
        else
        begin
            ovf_next = 1'b1;
        end
    end

    assign push                = act && p_last_reg;
    assign push_data.count     = 32'(count_next);
    assign push_data.sum_a     = sum_a_next;
    assign push_data.sum_b     = sum_b_next;
    assign push_data.sum_aa    = sum_aa_next;
    assign push_data.sum_bb    = sum_bb_next;
    assign push_data.sum_ab    = sum_ab_next;
    assign push_data.overflow  = ovf_next;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            p_a_reg  <= val_a;
            p_b_reg  <= val_b;
            p_aa_reg <= val_a * val_a;
            p_bb_reg <= val_b * val_b;
            p_ab_reg <= val_a * val_b;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg <= 1'b0;
            p_last_reg  <= 1'b0;
            count_reg   <= '0;
            sum_a_reg   <= '0;
            sum_b_reg   <= '0;
            sum_aa_reg  <= '0;
            sum_bb_reg  <= '0;
            sum_ab_reg  <= '0;
            ovf_reg     <= 1'b0;
        end
        else
        begin
            if (!blocked)
            begin
                p_valid_reg <= accept;
                if (accept)
                begin
                    p_last_reg <= sample.last;
                end
            end
            if (act)
            begin
                if (p_last_reg)
                begin
                    count_reg  <= '0;
                    sum_a_reg  <= '0;
                    sum_b_reg  <= '0;
                    sum_aa_reg <= '0;
                    sum_bb_reg <= '0;
                    sum_ab_reg <= '0;
                    ovf_reg    <= 1'b0;
                end
                else
                begin
                    count_reg  <= count_next;
                    sum_a_reg  <= sum_a_next;
                    sum_b_reg  <= sum_b_next;
                    sum_aa_reg <= sum_aa_next;
                    sum_bb_reg <= sum_bb_next;
                    sum_ab_reg <= sum_ab_next;
                    ovf_reg    <= ovf_next;
                end
            end
        end
    end

endmodule

[design/pcc_back.sv]
// ----------------------------------------------------------------------------
// pcc_back
// Turns the totals of one set into the rounded coefficient with a shared
// 32x32 multiplier and a 192-bit accumulator, then a bitwise search.
// ----------------------------------------------------------------------------
module pcc_back
    import pcc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      avail,
    input  pcc_snap_t pop_data,
    output logic      pop,
    output logic      result_valid,
    input  logic      result_stall,
    output pcc_out_t  result
);

    typedef enum logic [2:0] {S_IDLE, S_MUL, S_ACC, S_FIN, S_OUT} state_t;
    typedef enum logic [2:0] {PH_VA, PH_VB, PH_COV, PH_P, PH_R, PH_SQ, PH_K} phase_t;

    state_t         state_reg;
    phase_t         phase_reg;
    logic [2:0]     step_reg;
    pcc_snap_t      snap_reg;
    logic [63:0]    prod_reg;
    logic [191:0]   acc_reg;
    logic [63:0]    va_reg;
    logic [63:0]    vb_reg;
    logic [63:0]    mag_reg;
    logic           neg_reg;
    logic           degen_reg;
    logic [127:0]   p_reg;
    logic [127:0]   r_reg;
    logic [31:0]    odd2_reg;
    logic [15:0]    q_reg;
    logic [15:0]    cand_reg;
    logic [3:0]     bit_reg;
    logic           out_valid_reg;
    pcc_out_t       out_reg;

    logic [31:0]    op_a;
    logic [31:0]    op_b;
    logic [1:0]     off;
    logic           sub;
    logic           step_last;
    logic [191:0]   shifted;
    logic           fits;
    logic [15:0]    q_new;
    logic [15:0]    odd;
    logic [15:0]    corr;

    assign odd     = 16'({cand_reg, 1'b0} - 17'd1);
    assign shifted = {128'd0, prod_reg} << (32 * off);
    assign fits    = (acc_reg <= {32'd0, r_reg, 32'd0});
    assign q_new   = fits ? cand_reg : q_reg;
    assign pop     = (state_reg == S_IDLE) && avail;

    // Partial products of each phase; the lower 64 bits are exact modulo 2^64.
    always_comb
    begin
        op_a      = '0;
        op_b      = '0;
        off       = 2'd0;
        sub       = 1'b0;
        step_last = 1'b0;
        unique case (phase_reg) inside
            PH_VA, PH_VB, PH_COV:
            begin
                case (step_reg)
                    3'd0:
                    begin
                        op_a = snap_reg.count;
                        op_b = (phase_reg == PH_VA) ? snap_reg.sum_aa[31:0] :
                               (phase_reg == PH_VB) ? snap_reg.sum_bb[31:0] :
                                                      snap_reg.sum_ab[31:0];
                    end
                    3'd1:
                    begin
                        op_a = snap_reg.count;
                        op_b = (phase_reg == PH_VA) ? snap_reg.sum_aa[63:32] :
                               (phase_reg == PH_VB) ? snap_reg.sum_bb[63:32] :
                                                      snap_reg.sum_ab[63:32];
                        off  = 2'd1;
                    end
                    3'd2:
                    begin
                        op_a = (phase_reg == PH_VB) ? snap_reg.sum_b[31:0] : snap_reg.sum_a[31:0];
                        op_b = (phase_reg == PH_VA) ? snap_reg.sum_a[31:0] : snap_reg.sum_b[31:0];
                        sub  = 1'b1;
                    end
                    3'd3:
                    begin
                        op_a = (phase_reg == PH_VB) ? snap_reg.sum_b[31:0] : snap_reg.sum_a[31:0];
                        op_b = (phase_reg == PH_VA) ? snap_reg.sum_a[63:32] : snap_reg.sum_b[63:32];
                        off  = 2'd1;
                        sub  = 1'b1;
                    end
                    default:
                    begin
                        op_a      = (phase_reg == PH_VB) ? snap_reg.sum_b[63:32]
                                                         : snap_reg.sum_a[63:32];
                        op_b      = (phase_reg == PH_VA) ? snap_reg.sum_a[31:0]
                                                         : snap_reg.sum_b[31:0];
                        off       = 2'd1;
                        sub       = 1'b1;
                        step_last = 1'b1;
                    end
                endcase
            end
            PH_P, PH_R:
            begin
                case (step_reg[1:0])
                    2'd0:
                    begin
                        op_a = (phase_reg == PH_P) ? va_reg[31:0] : mag_reg[31:0];
                        op_b = (phase_reg == PH_P) ? vb_reg[31:0] : mag_reg[31:0];
                    end
                    2'd1:
                    begin
                        op_a = (phase_reg == PH_P) ? va_reg[31:0] : mag_reg[31:0];
                        op_b = (phase_reg == PH_P) ? vb_reg[63:32] : mag_reg[63:32];
                        off  = 2'd1;
                    end
                    2'd2:
                    begin
                        op_a = (phase_reg == PH_P) ? va_reg[63:32] : mag_reg[63:32];
                        op_b = (phase_reg == PH_P) ? vb_reg[31:0] : mag_reg[31:0];
                        off  = 2'd1;
                    end
                    default:
                    begin
                        op_a      = (phase_reg == PH_P) ? va_reg[63:32] : mag_reg[63:32];
                        op_b      = (phase_reg == PH_P) ? vb_reg[63:32] : mag_reg[63:32];
                        off       = 2'd2;
                        step_last = 1'b1;
                    end
                endcase
            end
            PH_SQ:
            begin
                op_a      = {16'd0, odd};
                op_b      = {16'd0, odd};
                step_last = 1'b1;
            end
            default:
            begin
                op_a      = odd2_reg;
                off       = step_reg[1:0];
                step_last = (step_reg[1:0] == 2'd3);
                case (step_reg[1:0])
                    2'd0:    op_b = p_reg[31:0];
                    2'd1:    op_b = p_reg[63:32];
                    2'd2:    op_b = p_reg[95:64];
                    default: op_b = p_reg[127:96];
                endcase
            end
        endcase
    end

    // A positive coefficient of exactly one saturates to the largest code.
    assign corr = neg_reg ? 16'(17'd0 - {1'b0, q_reg})
                          : (q_reg[15] ? 16'h7FFF : q_reg);

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            phase_reg     <= PH_VA;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // In the output state the valid flag is handled below.
            if (out_valid_reg && !result_stall && (state_reg != S_OUT))
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (avail)
                    begin
                        snap_reg  <= pop_data;
                        acc_reg   <= '0;
                        phase_reg <= PH_VA;
                        step_reg  <= '0;
                        state_reg <= S_MUL;
                    end
                end
                S_MUL:
                begin
                    prod_reg  <= op_a * op_b;
                    state_reg <= S_ACC;
                end
                S_ACC:
                begin
                    acc_reg <= sub ? acc_reg - shifted : acc_reg + shifted;
                    if (step_last)
                    begin
                        state_reg <= S_FIN;
                    end
                    else
                    begin
                        step_reg  <= step_reg + 1'b1;
                        state_reg <= S_MUL;
                    end
                end
                S_FIN:
                begin
                    acc_reg   <= '0;
                    step_reg  <= '0;
                    state_reg <= S_MUL;
                    unique case (phase_reg)
                        PH_VA:
                        begin
                            va_reg    <= acc_reg[63:0];
                            phase_reg <= PH_VB;
                        end
                        PH_VB:
                        begin
                            vb_reg    <= acc_reg[63:0];
                            phase_reg <= PH_COV;
                        end
                        PH_COV:
                        begin
                            neg_reg <= acc_reg[63];
                            mag_reg <= acc_reg[63] ? 64'd0 - acc_reg[63:0] : acc_reg[63:0];
                            if (va_reg == '0 || vb_reg == '0)
                            begin
                                degen_reg <= 1'b1;
                                q_reg     <= '0;
                                state_reg <= S_OUT;
                            end
                            else
                            begin
                                degen_reg <= 1'b0;
                                phase_reg <= PH_P;
                            end
                        end
                        PH_P:
                        begin
                            p_reg     <= acc_reg[127:0];
                            phase_reg <= PH_R;
                        end
                        PH_R:
                        begin
                            r_reg     <= acc_reg[127:0];
                            q_reg     <= '0;
                            bit_reg   <= 4'd15;
                            cand_reg  <= 16'h8000;
                            phase_reg <= PH_SQ;
                        end
                        PH_SQ:
                        begin
                            odd2_reg  <= acc_reg[31:0];
                            phase_reg <= PH_K;
                        end
                        default:
                        begin
                            phase_reg <= PH_SQ;
                            // The first trial tests a full-scale magnitude alone.
                            if (bit_reg == 4'd15)
                            begin
                                if (fits)
                                begin
                                    q_reg     <= 16'h8000;
                                    state_reg <= S_OUT;
                                end
                                else
                                begin
                                    q_reg    <= '0;
                                    bit_reg  <= 4'd14;
                                    cand_reg <= 16'h4000;
                                end
                            end
                            else
                            begin
                                q_reg <= q_new;
                                if (bit_reg == 4'd0)
                                begin
                                    state_reg <= S_OUT;
                                end
                                else
                                begin
                                    bit_reg  <= bit_reg - 1'b1;
                                    cand_reg <= q_new | (16'd1 << (bit_reg - 1'b1));
                                end
                            end
                        end
                    endcase
                end
                default:
                begin
                    if (!out_valid_reg || !result_stall)
                    begin
                        out_reg.correlation <= corr;
                        out_reg.degenerate  <= degen_reg;
                        out_reg.overflow    <= snap_reg.overflow;
                        out_valid_reg       <= 1'b1;
                        state_reg           <= S_IDLE;
                    end
                end
            endcase
        end
    end

endmodule

[design/pearson_correlation.sv]
// ----------------------------------------------------------------------------
// pearson_correlation
// Streaming Pearson correlation coefficient of paired Q1.15 samples.
// ----------------------------------------------------------------------------
// Sample pairs are taken at one per clock cycle while not stalled; each is
// registered with its products, then folded into exact running sums. A pair
// marked last closes the set, whose totals go into a two-entry queue, so the
// next set can be collected while the coefficient of the previous one is
// worked out. That work runs on one shared 32x32 multiplier, each partial
// product formed in S_MUL and added in S_ACC, and ends early when a
// variance is zero. Sample transactions stall only when a last pair meets a full queue.
// ----------------------------------------------------------------------------
module pearson_correlation
    import pcc_pkg::*;
#(
    parameter int MAX_SAMPLES = DEF_MAX_SAMPLES,
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     sample_valid,
    output logic     sample_stall,
    input  pcc_in_t  sample,
    output logic     result_valid,
    input  logic     result_stall,
    output pcc_out_t result
);

    logic      push;
    pcc_snap_t push_data;
    logic      full;
    logic      pop;
    logic      avail;
    pcc_snap_t pop_data;

    pcc_front #(
        .MAX_SAMPLES (MAX_SAMPLES),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .push         (push),
        .push_data    (push_data),
        .full         (full)
    );

    pcc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .avail     (avail),
        .pop_data  (pop_data)
    );

    pcc_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .avail        (avail),
        .pop_data     (pop_data),
        .pop          (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule
